// ===== hdl/hsvrgb_pkg.sv =====
// hsvrgb_pkg: shared types and constants for the HSV to RGB converter.
// No dependencies.
`timescale 1ns / 1ps

package hsvrgb_pkg;

	localparam int HUE_W    = 16;
	localparam int CH_W     = 8;
	localparam int WEIGHT_W = 9;
	localparam int PROD_W   = 2 * CH_W;

	// default depth of the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// floor(n / 3) for n < 512 as (n * RECIP3) >> RECIP3_SHIFT
	localparam int RECIP3       = 171;
	localparam int RECIP3_SHIFT = 9;
	// multiple of three that lifts floor(hue / 512) above zero
	localparam int TURN_BIAS    = 66;

	typedef enum logic [2:0] {
		SECT_RED_YELLOW    = 3'd0,
		SECT_YELLOW_GREEN  = 3'd1,
		SECT_GREEN_CYAN    = 3'd2,
		SECT_CYAN_BLUE     = 3'd3,
		SECT_BLUE_MAGENTA  = 3'd4,
		SECT_MAGENTA_RED   = 3'd5
	} sector_t;

	typedef struct packed {
		logic [CH_W-1:0]     chroma;
		logic [CH_W-1:0]     brightness;
		logic [WEIGHT_W-1:0] weight;
		sector_t             sector;
	} hsv_item_t;

endpackage

// ===== hdl/hsvrgb_front.sv =====
// hsvrgb_front: takes HSV words, wraps the hue into a sector and weight,
// and works out chroma in two stages. Depends on hsvrgb_pkg.
`timescale 1ns / 1ps

module hsvrgb_front
	import hsvrgb_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [HUE_W-1:0] hue,
	input  logic [CH_W-1:0]         saturation,
	input  logic [CH_W-1:0]         brightness,
	output logic                    out_valid,
	input  logic                    out_ready,
	output hsv_item_t               out_item
);

	logic                vld_s1, vld_s2;
	logic                s1_ready, s2_ready;
	logic [PROD_W-1:0]   prod_s1;
	logic [CH_W-1:0]     bri_s1;
	logic [WEIGHT_W-1:0] weight_s1;
	sector_t             sector_s1;
	hsv_item_t           item_s2;

	logic [7:0]          turn_n;
	logic [15:0]         recip_prod;
	logic [6:0]          turn_div;
	logic [7:0]          turn_mod;
	logic [8:0]          hue_low;
	logic [WEIGHT_W-1:0] weight;
	logic [PROD_W:0]     rounded;
	logic [PROD_W:0]     div_sum;

	assign s2_ready = !vld_s2 || out_ready;
	assign s1_ready = !vld_s1 || s2_ready;
	assign in_ready = s1_ready;

	// hue mod 1536: low nine bits give the place in a pair of sectors,
	// the upper seven bits taken mod 3 give the pair
	always_comb begin
		turn_n     = {hue[HUE_W-1], hue[HUE_W-1:9]} + 8'(TURN_BIAS);
		recip_prod = 16'(turn_n) * 16'(RECIP3);
		turn_div   = recip_prod[15:RECIP3_SHIFT];
		turn_mod   = turn_n - 8'(3 * turn_div);
		hue_low    = hue[8:0];
		if (hue_low[8]) begin
			weight = 9'(10'd512 - {1'b0, hue_low});
		end else begin
			weight = hue_low;
		end
	end

	// (p + 127) / 255 as (n + (n >> 8) + 1) >> 8
	always_comb begin
		rounded = {1'b0, prod_s1} + (PROD_W + 1)'(127);
		div_sum = rounded + (PROD_W + 1)'(rounded[PROD_W:CH_W]) + (PROD_W + 1)'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (s1_ready) begin
				vld_s1 <= in_valid;
			end
			if (s2_ready) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_ready && in_valid) begin
			prod_s1   <= PROD_W'(saturation) * PROD_W'(brightness);
			bri_s1    <= brightness;
			weight_s1 <= weight;
			sector_s1 <= sector_t'({turn_mod[1:0], hue_low[8]});
		end
		if (s2_ready && vld_s1) begin
			item_s2.chroma     <= div_sum[PROD_W-1:CH_W];
			item_s2.brightness <= bri_s1;
			item_s2.weight     <= weight_s1;
			item_s2.sector     <= sector_s1;
		end
	end

	assign out_valid = vld_s2;
	assign out_item  = item_s2;

endmodule

// ===== hdl/hsvrgb_queue.sv =====
// hsvrgb_queue: short register queue between front and back.
// Depends on hsvrgb_pkg.
`timescale 1ns / 1ps

module hsvrgb_queue
	import hsvrgb_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  hsv_item_t in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output hsv_item_t out_item
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	hsv_item_t        entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push, pop;

	assign in_ready  = count_q != CNT_W'(DEPTH);
	assign out_valid = count_q != '0;
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_item;
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");
	a_push_only: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count missed a push");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0 || count_q == CNT_W'(DEPTH)) |-> wr_ptr_q == rd_ptr_q)
		else $error("queue pointers out of step with count");
`endif

endmodule

// ===== hdl/hsvrgb_back.sv =====
// hsvrgb_back: forms the secondary term, places channels by sector and
// adds the offset; drives the result register. Depends on hsvrgb_pkg.
`timescale 1ns / 1ps

module hsvrgb_back
	import hsvrgb_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  hsv_item_t       in_item,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [CH_W-1:0] red,
	output logic [CH_W-1:0] green,
	output logic [CH_W-1:0] blue
);

	logic            vld_s1, vld_s2;
	logic            s1_ready, s2_ready;
	logic [CH_W-1:0] x_s1, c_s1, m_s1;
	sector_t         sector_s1;
	logic [CH_W-1:0] red_s2, green_s2, blue_s2;

	logic [PROD_W:0] x_sum;
	logic [CH_W-1:0] r_sel, g_sel, b_sel;

	assign s2_ready = !vld_s2 || out_ready;
	assign s1_ready = !vld_s1 || s2_ready;
	assign in_ready = s1_ready;

	assign x_sum = (PROD_W + 1)'(in_item.chroma) * (PROD_W + 1)'(in_item.weight)
		+ (PROD_W + 1)'(128);

	always_comb begin
		unique case (sector_s1)
			SECT_RED_YELLOW: begin
				r_sel = c_s1; g_sel = x_s1; b_sel = '0;
			end
			SECT_YELLOW_GREEN: begin
				r_sel = x_s1; g_sel = c_s1; b_sel = '0;
			end
			SECT_GREEN_CYAN: begin
				r_sel = '0; g_sel = c_s1; b_sel = x_s1;
			end
			SECT_CYAN_BLUE: begin
				r_sel = '0; g_sel = x_s1; b_sel = c_s1;
			end
			SECT_BLUE_MAGENTA: begin
				r_sel = x_s1; g_sel = '0; b_sel = c_s1;
			end
			default: begin
				r_sel = c_s1; g_sel = '0; b_sel = x_s1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (s1_ready) begin
				vld_s1 <= in_valid;
			end
			if (s2_ready) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_ready && in_valid) begin
			x_s1      <= x_sum[PROD_W-1:CH_W];
			c_s1      <= in_item.chroma;
			m_s1      <= in_item.brightness - in_item.chroma;
			sector_s1 <= in_item.sector;
		end
		if (s2_ready && vld_s1) begin
			red_s2   <= r_sel + m_s1;
			green_s2 <= g_sel + m_s1;
			blue_s2  <= b_sel + m_s1;
		end
	end

	assign out_valid = vld_s2;
	assign red       = red_s2;
	assign green     = green_s2;
	assign blue      = blue_s2;

endmodule

// ===== hdl/hsv_to_rgb_convert.sv =====
// hsv_to_rgb_convert: HSV to RGB pixel converter, top level.
// Path: front stages s1 and s2, then the queue, then back stages s1 and s2.
// Throughput: one word per cycle unless m_tready is low or the queue is full.
// Reset: arst_n clears stage valids and the queue count; no clearing pass.
// Depends on hsvrgb_pkg, hsvrgb_front, hsvrgb_queue, hsvrgb_back.
`timescale 1ns / 1ps

module hsv_to_rgb_convert
	import hsvrgb_pkg::*;
#(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // hue[15:0], saturation[23:16], brightness[31:24]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // red[7:0], green[15:8], blue[23:16]
);

	logic      f_valid, f_ready;
	hsv_item_t f_item;
	logic      q_valid, q_ready;
	hsv_item_t q_item;

	hsvrgb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.hue        (s_tdata[15:0]),
		.saturation (s_tdata[23:16]),
		.brightness (s_tdata[31:24]),
		.out_valid  (f_valid),
		.out_ready  (f_ready),
		.out_item   (f_item)
	);

	hsvrgb_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_item   (f_item),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_item  (q_item)
	);

	hsvrgb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_valid),
		.in_ready  (q_ready),
		.in_item   (q_item),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.red       (m_tdata[7:0]),
		.green     (m_tdata[15:8]),
		.blue      (m_tdata[23:16])
	);

endmodule

// ===== sim/testbench.sv =====
// testbench: self-checking bench for hsv_to_rgb_convert, directed table then random words.
// Predicts each RGB word locally and compares in order; depends on hsvrgb_pkg and the RTL.
`timescale 1ns / 1ps

module testbench
	import hsvrgb_pkg::*;
();

	localparam int SECTOR_UNITS = 256;
	localparam int TURN_UNITS   = 6 * SECTOR_UNITS;
	localparam int CH_MAX       = (1 << CH_W) - 1;
	localparam int RANDOM_WORDS = 1750;
	localparam int QUIET_FROM   = 1500;
	localparam int HOLD_AT      = 500;
	localparam int HOLD_CYCLES  = 300;
	localparam int CYCLE_LIMIT  = 500000;

	typedef struct packed {
		logic [CH_W-1:0]         brightness;
		logic [CH_W-1:0]         saturation;
		logic signed [HUE_W-1:0] hue;
	} hsv_word_t;

	typedef struct packed {
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] red;
	} rgb_word_t;

	typedef struct {
		hsv_word_t px;
		bit        known;
		rgb_word_t rgb;
	} table_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;  // hue[15:0], saturation[23:16], brightness[31:24]
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;  // red[7:0], green[15:8], blue[23:16]

	rgb_word_t  pending_rgb[$];
	table_row_t pixel_table[$];
	int         err_cnt;
	int         accepted_cnt;
	int         cycle_cnt;
	bit         quiet;

	hsv_to_rgb_convert i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic rgb_word_t hsv_pixel_to_rgb(hsv_word_t px);
		int        h;
		int        span;
		int        c;
		int        x;
		int        m;
		int        r;
		int        g;
		int        b;
		sector_t   sect;
		rgb_word_t res;
		h = int'(px.hue) % TURN_UNITS;
		if (h < 0) begin
			h += TURN_UNITS;
		end
		c = (int'(px.brightness) * int'(px.saturation) + 127) / CH_MAX;
		sect = sector_t'(h / SECTOR_UNITS);
		span = (h % (2 * SECTOR_UNITS)) - SECTOR_UNITS;
		if (span < 0) begin
			span = -span;
		end
		x = (c * (SECTOR_UNITS - span) + 128) >> 8;
		m = int'(px.brightness) - c;
		case (sect)
			SECT_RED_YELLOW: begin
				r = c; g = x; b = 0;
			end
			SECT_YELLOW_GREEN: begin
				r = x; g = c; b = 0;
			end
			SECT_GREEN_CYAN: begin
				r = 0; g = c; b = x;
			end
			SECT_CYAN_BLUE: begin
				r = 0; g = x; b = c;
			end
			SECT_BLUE_MAGENTA: begin
				r = x; g = 0; b = c;
			end
			default: begin
				r = c; g = 0; b = x;
			end
		endcase
		res.red   = CH_W'(r + m);
		res.green = CH_W'(g + m);
		res.blue  = CH_W'(b + m);
		return res;
	endfunction

	task automatic add_row(int hue, int sat, int val, bit known, int r, int g, int b);
		table_row_t row;
		row.px.hue        = HUE_W'(hue);
		row.px.saturation = CH_W'(sat);
		row.px.brightness = CH_W'(val);
		row.known         = known;
		row.rgb.red       = CH_W'(r);
		row.rgb.green     = CH_W'(g);
		row.rgb.blue      = CH_W'(b);
		pixel_table.push_back(row);
	endtask

	task automatic send_pixel(hsv_word_t px, rgb_word_t want);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= px;
		do begin
			@(posedge clk);
		end while (!s_tready);
		pending_rgb.push_back(want);
		accepted_cnt++;
	endtask

	task automatic sender_gap(int n);
		@(negedge clk);
		s_tvalid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	function automatic logic [CH_W-1:0] pick_channel();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return CH_W'(CH_MAX);
			default: return CH_W'($urandom);
		endcase
	endfunction

	function automatic hsv_word_t random_pixel();
		hsv_word_t px;
		int        k;
		k = $urandom_range(0, 9);
		if (k <= 3) begin
			px.hue = HUE_W'($urandom);
		end else if (k <= 5) begin
			px.hue = HUE_W'($urandom_range(0, TURN_UNITS - 1));
		end else if (k <= 8) begin
			// near a sector edge, possibly up to 20 turns away
			px.hue = HUE_W'(int'($urandom_range(0, 6)) * SECTOR_UNITS
				+ int'($urandom_range(0, 4)) - 2
				+ (int'($urandom_range(0, 40)) - 20) * TURN_UNITS);
		end else begin
			px.hue = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
		end
		px.saturation = pick_channel();
		px.brightness = pick_channel();
		return px;
	endfunction

	always @(posedge clk) begin
		rgb_word_t got;
		rgb_word_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_rgb.size() == 0) begin
				err_cnt++;
				if (err_cnt <= 10) begin
					$display("unexpected word: r=%0d g=%0d b=%0d", got.red, got.green, got.blue);
				end
			end else begin
				want = pending_rgb.pop_front();
				if (got.red !== want.red || got.green !== want.green
						|| got.blue !== want.blue) begin
					err_cnt++;
					if (err_cnt <= 10) begin
						$display("mismatch: exp r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
							want.red, want.green, want.blue, got.red, got.green, got.blue);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// receiver: random back-pressure, one long hold to fill the pipe
	initial begin
		bit hold_done;
		hold_done = 1'b0;
		m_tready  = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (!hold_done && accepted_cnt >= HOLD_AT) begin
				hold_done = 1'b1;
				m_tready <= 1'b0;
				for (int k = 0; k < HOLD_CYCLES; k++) begin
					@(negedge clk);
				end
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 16)) @(negedge clk);
			end
		end
	end

	initial begin
		hsv_word_t px;
		rgb_word_t want;
		err_cnt      = 0;
		accepted_cnt = 0;
		cycle_cnt    = 0;
		quiet        = 1'b0;
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;

		// full colour at each sector edge, wrap, grey, black and white, then words predicted by hsv_pixel_to_rgb
		add_row(0,      255, 255, 1, 255, 0,   0);
		add_row(256,    255, 255, 1, 255, 255, 0);
		add_row(512,    255, 255, 1, 0,   255, 0);
		add_row(768,    255, 255, 1, 0,   255, 255);
		add_row(1024,   255, 255, 1, 0,   0,   255);
		add_row(1280,   255, 255, 1, 255, 0,   255);
		add_row(1536,   255, 255, 1, 255, 0,   0);
		add_row(-1536,  255, 255, 1, 255, 0,   0);
		add_row(-32768, 255, 255, 1, 0,   0,   255);
		add_row(300,    0,   200, 1, 200, 200, 200);
		add_row(-1,     0,   0,   1, 0,   0,   0);
		add_row(700,    255, 0,   1, 0,   0,   0);
		add_row(32767,  0,   255, 1, 255, 255, 255);
		add_row(-1,     255, 255, 0, 0, 0, 0);
		add_row(32767,  255, 255, 0, 0, 0, 0);
		add_row(128,    128, 128, 0, 0, 0, 0);
		add_row(255,    200, 100, 0, 0, 0, 0);
		add_row(257,    1,   254, 0, 0, 0, 0);
		add_row(1535,   255, 1,   0, 0, 0, 0);
		add_row(511,    77,  180, 0, 0, 0, 0);
		add_row(1023,   254, 255, 0, 0, 0, 0);
		add_row(-257,   255, 255, 0, 0, 0, 0);
		add_row(100,    255, 128, 0, 0, 0, 0);
		add_row(12345,  170, 85,  0, 0, 0, 0);
		add_row(-20000, 85,  170, 0, 0, 0, 0);

		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		foreach (pixel_table[i]) begin
			want = pixel_table[i].known ? pixel_table[i].rgb
				: hsv_pixel_to_rgb(pixel_table[i].px);
			send_pixel(pixel_table[i].px, want);
		end

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i == QUIET_FROM) begin
				quiet = 1'b1;
			end
			if (!quiet && $urandom_range(0, 4) == 0) begin
				sender_gap($urandom_range(1, 11));
			end
			px = random_pixel();
			send_pixel(px, hsv_pixel_to_rgb(px));
		end
		@(negedge clk);
		s_tvalid <= 1'b0;

		while (pending_rgb.size() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
		if (err_cnt == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hdl/hsvrgb_pkg.sv
hdl/hsvrgb_front.sv
hdl/hsvrgb_queue.sv
hdl/hsvrgb_back.sv
hdl/hsv_to_rgb_convert.sv
sim/testbench.sv
